FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/aabb_pkg.sv
`timescale 1ns / 1ps

package aabb_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + COORD_BITS;
  localparam int NUM_AXES   = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_RAY   = 2'd2,
    CMD_SPAN  = 2'd3
  } cmd_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Drop the fraction bits (floor) and clamp to the coordinate range.
  function automatic coord_t scale_sat(prod_t p);
    prod_t                           sh;
    logic [PROD_BITS-COORD_BITS:0]   top;
    coord_t                          res;
    sh  = p >>> FRAC_BITS;
    top = sh[PROD_BITS-1:COORD_BITS-1];
    if ((&top) || !(|top)) begin
      res = sh[COORD_BITS-1:0];
    end else if (sh[PROD_BITS-1]) begin
      res = COORD_MIN;
    end else begin
      res = COORD_MAX;
    end
    return res;
  endfunction

endpackage

FILE: rtl/aabb_build_and_ray_slab_test.sv
`timescale 1ns / 1ps

// Box builder and ray slab tester. Each item carries a command: clear the box, add a
// point to it, run the ray test (entry clamped at zero) or run the interval test
// against [in_t_near, in_t_far]. Every item returns exactly one out_hit, which is
// 0 for clear and add items. Coordinates are signed Q16.16. The block is a
// three-register pipeline: the input register feeds six slab multipliers whose
// exact products are registered, the second stage scales, saturates and runs the
// min/max compare chain into the output register. One item is accepted every
// cycle unless out_ready stalls it; an item passes the input, product and output
// registers, and stalls back up through the stages without losing items. The box is
// updated when an item leaves the input register, so a test right after an add
// point sees the widened box. After reset the box is empty (inverted corners).
`include "assert_macros.svh"

module aabb_build_and_ray_slab_test import aabb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_command,
  input  coord_t       in_px,
  input  coord_t       in_py,
  input  coord_t       in_pz,
  input  coord_t       in_ix,
  input  coord_t       in_iy,
  input  coord_t       in_iz,
  input  coord_t       in_t_near,
  input  coord_t       in_t_far,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_hit
);

  // Stage 1: input register
  logic   s1_v_r;
  cmd_t   s1_cmd_r;
  coord_t s1_p_r [NUM_AXES];
  coord_t s1_i_r [NUM_AXES];
  coord_t s1_tn_r, s1_tf_r;

  // Stage 2: registered products
  logic   s2_v_r;
  cmd_t   s2_cmd_r;
  prod_t  s2_plo_r [NUM_AXES];
  prod_t  s2_phi_r [NUM_AXES];
  logic   s2_ineg_r [NUM_AXES];
  coord_t s2_tn_r, s2_tf_r;

  // Output register
  logic   out_v_r;
  logic   out_hit_r;
  logic   hit_nxt;

  // Box corners
  coord_t box_lo_r [NUM_AXES];
  coord_t box_hi_r [NUM_AXES];

  logic out_ok, s2_ready, s2_adv, s1_adv, in_acc;

  // Each stage moves on when the one after it is empty or moving.
  assign out_ok   = !out_v_r || out_ready;
  assign s2_ready = !s2_v_r || out_ok;
  assign s2_adv   = s2_v_r && out_ok;
  assign s1_adv   = s1_v_r && s2_ready;
  assign in_ready = !s1_v_r || s2_ready;
  assign in_acc   = in_valid && in_ready;

  assign out_valid = out_v_r;
  assign out_hit   = out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) s1_v_r  <= in_valid;
      if (s2_ready) s2_v_r  <= s1_v_r;
      if (out_ok)   out_v_r <= s2_v_r;
    end
  end

  // Capture the item.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= cmd_t'(in_command);
      s1_p_r[0] <= in_px;
      s1_p_r[1] <= in_py;
      s1_p_r[2] <= in_pz;
      s1_i_r[0] <= in_ix;
      s1_i_r[1] <= in_iy;
      s1_i_r[2] <= in_iz;
      s1_tn_r   <= in_t_near;
      s1_tf_r   <= in_t_far;
    end
  end

  // Slab products against the current box.
  prod_t plo [NUM_AXES];
  prod_t phi [NUM_AXES];

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    aabb_slab u_slab_lo (
      .bound  (box_lo_r[k]),
      .origin (s1_p_r[k]),
      .inv    (s1_i_r[k]),
      .prod   (plo[k])
    );
    aabb_slab u_slab_hi (
      .bound  (box_hi_r[k]),
      .origin (s1_p_r[k]),
      .inv    (s1_i_r[k]),
      .prod   (phi[k])
    );
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_cmd_r <= s1_cmd_r;
      s2_tn_r  <= s1_tn_r;
      s2_tf_r  <= s1_tf_r;
      for (int k = 0; k < NUM_AXES; k++) begin
        s2_plo_r[k]  <= plo[k];
        s2_phi_r[k]  <= phi[k];
        s2_ineg_r[k] <= s1_i_r[k][COORD_BITS-1];
      end
    end
  end

  // Update the box as the item leaves stage 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        box_lo_r[k] <= COORD_MAX;
        box_hi_r[k] <= COORD_MIN;
      end
    end else if (s1_adv) begin
      if (s1_cmd_r == CMD_CLEAR) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          box_lo_r[k] <= COORD_MAX;
          box_hi_r[k] <= COORD_MIN;
        end
      end else if (s1_cmd_r == CMD_ADD) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          if (s1_p_r[k] < box_lo_r[k]) box_lo_r[k] <= s1_p_r[k];
          if (s1_p_r[k] > box_hi_r[k]) box_hi_r[k] <= s1_p_r[k];
        end
      end
    end
  end

  // Stage 2: scale, saturate and compare.
  coord_t t_lo [NUM_AXES];
  coord_t t_hi [NUM_AXES];
  coord_t mn [NUM_AXES];
  coord_t mx [NUM_AXES];
  coord_t tn_ax [NUM_AXES];
  coord_t tf_ax [NUM_AXES];
  coord_t entry_01, entry, exit_01, exit_t;
  coord_t tmin1, tmax1, tmin2, tmax2;
  logic   ray_hit, span_hit, miss1, miss2;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      t_lo[k]  = scale_sat(s2_plo_r[k]);
      t_hi[k]  = scale_sat(s2_phi_r[k]);
      mn[k]    = (t_lo[k] < t_hi[k]) ? t_lo[k] : t_hi[k];
      mx[k]    = (t_lo[k] < t_hi[k]) ? t_hi[k] : t_lo[k];
      // Near slab uses the high corner when the direction is negative.
      tn_ax[k] = s2_ineg_r[k] ? t_hi[k] : t_lo[k];
      tf_ax[k] = s2_ineg_r[k] ? t_lo[k] : t_hi[k];
    end

    // Ray test: entry clamped at zero.
    entry_01 = (mn[1] > mn[0]) ? mn[1] : mn[0];
    entry    = (mn[2] > entry_01) ? mn[2] : entry_01;
    exit_01  = (mx[1] < mx[0]) ? mx[1] : mx[0];
    exit_t   = (mx[2] < exit_01) ? mx[2] : exit_01;
    ray_hit  = (exit_t >= entry) && !exit_t[COORD_BITS-1];

    // Interval test: running near/far, miss as soon as they cross.
    miss1    = (tn_ax[0] > tf_ax[1]) || (tn_ax[1] > tf_ax[0]);
    tmin1    = (tn_ax[1] > tn_ax[0]) ? tn_ax[1] : tn_ax[0];
    tmax1    = (tf_ax[1] < tf_ax[0]) ? tf_ax[1] : tf_ax[0];
    miss2    = (tmin1 > tf_ax[2]) || (tn_ax[2] > tmax1);
    tmin2    = (tn_ax[2] > tmin1) ? tn_ax[2] : tmin1;
    tmax2    = (tf_ax[2] < tmax1) ? tf_ax[2] : tmax1;
    span_hit = !miss1 && !miss2 && (tmin2 < s2_tf_r) && (tmax2 > s2_tn_r);

    unique case (s2_cmd_r)
      CMD_CLEAR: hit_nxt = 1'b0;
      CMD_ADD:   hit_nxt = 1'b0;
      CMD_RAY:   hit_nxt = ray_hit;
      CMD_SPAN:  hit_nxt = span_hit;
      default:   hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_hit_r <= hit_nxt;
    end
  end

  // Checks
  `ASSERT_NEXT(a_clear_box, clk, rst_n, s1_adv && (s1_cmd_r == CMD_CLEAR), (box_lo_r[0] == COORD_MAX) && (box_hi_r[2] == COORD_MIN), "clear item did not empty the box")
  `ASSERT_NEXT(a_add_order, clk, rst_n, s1_adv && (s1_cmd_r == CMD_ADD), (box_lo_r[0] <= box_hi_r[0]) && (box_lo_r[1] <= box_hi_r[1]) && (box_lo_r[2] <= box_hi_r[2]), "box corners crossed after add point")
  `ASSERT_NEXT(a_build_no_hit, clk, rst_n, s2_adv && ((s2_cmd_r == CMD_CLEAR) || (s2_cmd_r == CMD_ADD)), out_v_r && !out_hit_r, "build item produced a hit")

endmodule

FILE: rtl/aabb_slab.sv
`timescale 1ns / 1ps

// Exact slab product (bound - origin) * inverse direction.
module aabb_slab import aabb_pkg::*; (
  input  coord_t bound,
  input  coord_t origin,
  input  coord_t inv,
  output prod_t  prod
);

  diff_t diff;

  assign diff = DIFF_BITS'(bound) - DIFF_BITS'(origin);
  assign prod = PROD_BITS'(diff) * PROD_BITS'(inv);

endmodule
